>>> hw/rtl/rmsl_pkg.sv
package rmsl_pkg;

	localparam int MAX_ROWS       = 1024;
	localparam int MAX_ROW_LENGTH = 4096;
	localparam int SAMPLE_BITS    = 16;

	localparam int ROW_BITS    = $clog2(MAX_ROWS);
	localparam int POS_BITS    = $clog2(MAX_ROW_LENGTH);
	localparam int LEN_BITS    = 13;
	localparam int CNT_BITS    = 11;
	localparam int SUM_BITS    = 29;
	localparam int MEAN_BITS   = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int LOSS_BITS   = 32;
	localparam int GRAD_BITS   = 32;
	localparam int SQSUM_BITS  = 42;
	localparam int SQ_BITS     = 2 * MEAN_BITS - 1;

	// shared divider: widest dividend is the square sum, widest divisor rows*length
	localparam int DIV_BITS = SQSUM_BITS;
	localparam int DVS_BITS = 23;

	localparam int QUEUE_DEPTH = 2;

	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = LEN_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT  = 1'b1;

	typedef enum logic {
		CMD_FORWARD  = 1'b0,
		CMD_BACKWARD = 1'b1
	} cmd_t;

	typedef enum logic {
		KIND_FORWARD  = 1'b0,
		KIND_BACKWARD = 1'b1
	} kind_t;

	typedef struct packed {
		cmd_t                          cmd;
		logic [ROW_BITS-1:0]           row;
		logic signed [SUM_BITS-1:0]    sum;
		logic signed [WEIGHT_BITS-1:0] weight;
		logic                          last;
		logic [LEN_BITS-1:0]           len;
		logic [CNT_BITS-1:0]           rows;
	} job_t;

	typedef struct packed {
		kind_t                       kind;
		logic [ROW_BITS-1:0]         row;
		logic signed [MEAN_BITS-1:0] mean;
		logic                        loss_valid;
		logic [LOSS_BITS-1:0]        loss;
		logic signed [GRAD_BITS-1:0] gradient;
	} result_t;

	typedef struct packed {
		logic                start;
		logic [DIV_BITS-1:0] dividend;
		logic [DVS_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIV_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

>>> hw/rtl/row_mean_square_loss.sv
// mid-row samples are accepted at one sample per cycle while the job queue is not full
// a row end gives its mean, a batch end its mean and loss, and a gradient request its gradient,
// each computed by the shared one-bit-per-cycle 42-step divider
// a two-entry job queue lets samples keep flowing while the divider works
// asynchronous active-low reset clears all control, row_length and row_count go to 1,
// stored means are not cleared
module row_mean_square_loss
	import rmsl_pkg::*;
	(
		input  logic                          clk,
		input  logic                          arst_n,
		input  logic                          push,
		output logic                          full,
		input  logic                          command,
		input  logic signed [SAMPLE_BITS-1:0] sample,
		input  logic [ROW_BITS-1:0]           row_select,
		input  logic signed [WEIGHT_BITS-1:0] loss_weight,
		output logic                          empty,
		input  logic                          pop,
		output logic                          result_kind,
		output logic [ROW_BITS-1:0]           row_number,
		output logic signed [MEAN_BITS-1:0]   row_mean,
		output logic                          loss_valid,
		output logic [LOSS_BITS-1:0]          loss,
		output logic signed [GRAD_BITS-1:0]   gradient,
		input  logic                          write_enable,
		input  logic [CFG_INDEX_BITS-1:0]     write_index,
		input  logic [CFG_DATA_BITS-1:0]      write_data
	);

	job_t    front_job;
	job_t    head_job;
	logic    job_push;
	logic    job_pop;
	logic    queue_full;
	logic    queue_empty;
	result_t res;
	logic    res_valid;

	rmsl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.command     (command),
		.sample      (sample),
		.row_select  (row_select),
		.loss_weight (loss_weight),
		.write_enable(write_enable),
		.write_index (write_index),
		.write_data  (write_data),
		.queue_full  (queue_full),
		.job_push    (job_push),
		.job         (front_job)
	);

	rmsl_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.din   (front_job),
		.pop   (job_pop),
		.dout  (head_job),
		.full  (queue_full),
		.empty (queue_empty)
	);

	rmsl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (head_job),
		.job_empty(queue_empty),
		.job_pop  (job_pop),
		.res_pop  (pop),
		.res      (res),
		.res_valid(res_valid)
	);

	assign full        = queue_full;
	assign empty       = !res_valid;
	assign result_kind = res.kind;
	assign row_number  = res.row;
	assign row_mean    = res.mean;
	assign loss_valid  = res.loss_valid;
	assign loss        = res.loss;
	assign gradient    = res.gradient;

	// a gradient request always lands in the job queue
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && (command == CMD_BACKWARD) |=> !queue_empty)
		else $error("gradient request not queued");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result_kind == KIND_BACKWARD) |-> !loss_valid && (loss == '0))
		else $error("gradient result carries a loss");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result_kind == KIND_FORWARD) && !loss_valid |-> (loss == '0) && (gradient == '0))
		else $error("row mean result carries loss or gradient");

endmodule

>>> hw/rtl/rmsl_ram.sv
module rmsl_ram
	#(
		parameter int WIDTH = 16,
		parameter int DEPTH = 1024,
		localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
	)
	(
		input  logic                 clk,
		input  logic                 we,
		input  logic [ADDR_BITS-1:0] waddr,
		input  logic [WIDTH-1:0]     wdata,
		input  logic [ADDR_BITS-1:0] raddr,
		output logic [WIDTH-1:0]     rdata
	);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/rmsl_queue.sv
module rmsl_queue
	import rmsl_pkg::*;
	(
		input  logic clk,
		input  logic arst_n,
		input  logic push,
		input  job_t din,
		input  logic pop,
		output job_t dout,
		output logic full,
		output logic empty
	);

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

	job_t                slot_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                wr;
	logic                rd;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

>>> hw/rtl/rmsl_div.sv
module rmsl_div
	import rmsl_pkg::*;
	(
		input  logic     clk,
		input  logic     arst_n,
		input  div_req_t req,
		output div_rsp_t rsp
	);

	localparam int CNT_W = $clog2(DIV_BITS);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DVS_BITS-1:0] rem_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [DVS_BITS-1:0] dvs_q;
	logic [DVS_BITS:0]   shifted;
	logic [DVS_BITS:0]   diff;
	logic                fits;
	logic                last_step;

	// restoring division, one quotient bit per cycle
	assign shifted   = {rem_q, quo_q[DIV_BITS-1]};
	assign fits      = (shifted >= {1'b0, dvs_q});
	assign diff      = shifted - {1'b0, dvs_q};
	assign last_step = (cnt_q == CNT_W'(DIV_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_BITS-1:0] : shifted[DVS_BITS-1:0];
			quo_q <= {quo_q[DIV_BITS-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> hw/rtl/rmsl_front.sv
module rmsl_front
	import rmsl_pkg::*;
	(
		input  logic                          clk,
		input  logic                          arst_n,
		input  logic                          push,
		input  logic                          command,
		input  logic signed [SAMPLE_BITS-1:0] sample,
		input  logic [ROW_BITS-1:0]           row_select,
		input  logic signed [WEIGHT_BITS-1:0] loss_weight,
		input  logic                          write_enable,
		input  logic [CFG_INDEX_BITS-1:0]     write_index,
		input  logic [CFG_DATA_BITS-1:0]      write_data,
		input  logic                          queue_full,
		output logic                          job_push,
		output job_t                          job
	);

	logic [LEN_BITS-1:0]        row_length_q;
	logic [CNT_BITS-1:0]        row_count_q;
	logic signed [SUM_BITS-1:0] row_sum_q;
	logic [POS_BITS-1:0]        pos_q;
	logic [ROW_BITS-1:0]        cur_row_q;

	logic [LEN_BITS-1:0]        len_eff;
	logic [CNT_BITS-1:0]        rows_eff;
	logic signed [SUM_BITS-1:0] sum_next;
	logic                       accept;
	logic                       row_end;
	logic                       last;
	cmd_t                       cmd;

	always_comb begin
		if (row_length_q == '0) begin
			len_eff = LEN_BITS'(1);
		end else if (row_length_q > LEN_BITS'(MAX_ROW_LENGTH)) begin
			len_eff = LEN_BITS'(MAX_ROW_LENGTH);
		end else begin
			len_eff = row_length_q;
		end
		if (row_count_q == '0) begin
			rows_eff = CNT_BITS'(1);
		end else if (row_count_q > CNT_BITS'(MAX_ROWS)) begin
			rows_eff = CNT_BITS'(MAX_ROWS);
		end else begin
			rows_eff = row_count_q;
		end
	end

	assign cmd      = cmd_t'(command);
	assign accept   = push && !queue_full;
	assign sum_next = row_sum_q + SUM_BITS'(sample);
	assign row_end  = ((LEN_BITS'(pos_q) + 1'b1) >= len_eff);
	assign last     = ((CNT_BITS'(cur_row_q) + 1'b1) >= rows_eff);
	assign job_push = accept && ((cmd == CMD_BACKWARD) || row_end);

	always_comb begin
		job.cmd    = cmd;
		job.row    = (cmd == CMD_BACKWARD) ? row_select : cur_row_q;
		job.sum    = sum_next;
		job.weight = loss_weight;
		job.last   = last;
		job.len    = len_eff;
		job.rows   = rows_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= LEN_BITS'(1);
			row_count_q  <= CNT_BITS'(1);
			row_sum_q    <= '0;
			pos_q        <= '0;
			cur_row_q    <= '0;
		end else begin
			if (write_enable) begin
				case (write_index)
					REG_ROW_LENGTH: begin
						row_length_q <= write_data[LEN_BITS-1:0];
					end
					REG_ROW_COUNT: begin
						row_count_q <= write_data[CNT_BITS-1:0];
					end
					default: begin
						row_length_q <= row_length_q;
					end
				endcase
			end
			if (accept && (cmd == CMD_FORWARD)) begin
				if (row_end) begin
					row_sum_q <= '0;
					pos_q     <= '0;
					cur_row_q <= last ? '0 : cur_row_q + 1'b1;
				end else begin
					row_sum_q <= sum_next;
					pos_q     <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> hw/rtl/rmsl_back.sv
module rmsl_back
	import rmsl_pkg::*;
	(
		input  logic    clk,
		input  logic    arst_n,
		input  job_t    job,
		input  logic    job_empty,
		output logic    job_pop,
		input  logic    res_pop,
		output result_t res,
		output logic    res_valid
	);

	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_READ      = 8'b0000_0010,
		ST_WAIT_GRAD = 8'b0000_0100,
		ST_WAIT_MEAN = 8'b0000_1000,
		ST_SQUARE    = 8'b0001_0000,
		ST_ACCUM     = 8'b0010_0000,
		ST_WAIT_LOSS = 8'b0100_0000,
		ST_DONE      = 8'b1000_0000
	} state_t;

	localparam logic [DIV_BITS-1:0] MEAN_POS_MAX = DIV_BITS'(16'h7FFF);
	localparam logic [DIV_BITS-1:0] MEAN_NEG_MAX = DIV_BITS'(16'h8000);
	localparam logic [DIV_BITS-1:0] GRAD_POS_MAX = DIV_BITS'(32'h7FFF_FFFF);
	localparam logic [DIV_BITS-1:0] GRAD_NEG_MAX = DIV_BITS'(32'h8000_0000);
	localparam logic [DIV_BITS-1:0] LOSS_MAX     = DIV_BITS'(32'hFFFF_FFFF);
	localparam int NUM_BITS = 2 * WEIGHT_BITS + 1;
	localparam int DEN_BITS = LEN_BITS + CNT_BITS;

	state_t                      state_q;
	logic                        res_valid_q;
	logic [SQSUM_BITS-1:0]       square_sum_q;
	result_t                     res_q;
	job_t                        job_q;
	logic                        sign_q;
	logic signed [MEAN_BITS-1:0] mean_q;
	logic [SQ_BITS-1:0]          sq_q;
	logic [LOSS_BITS-1:0]        loss_q;
	logic signed [GRAD_BITS-1:0] grad_q;

	logic signed [MEAN_BITS-1:0] mean_rd;
	logic                        ram_we;
	logic signed [2*MEAN_BITS-1:0] wm;
	logic signed [NUM_BITS-1:0]  num;
	logic [NUM_BITS-1:0]         num_abs;
	logic [DEN_BITS-1:0]         den_full;
	logic [SUM_BITS-1:0]         sum_abs;
	logic signed [2*MEAN_BITS-1:0] sq_full;
	logic [SQSUM_BITS-1:0]       sqsum_next;
	logic [DIV_BITS-1:0]         q;
	logic signed [MEAN_BITS-1:0] mean_sat;
	logic signed [GRAD_BITS-1:0] grad_sat;
	logic [LOSS_BITS-1:0]        loss_sat;
	logic                        out_free;
	div_req_t                    div_req;
	div_rsp_t                    div_rsp;
	result_t                     res_next;

	assign job_pop  = (state_q == ST_IDLE) && !job_empty;
	assign ram_we   = (state_q == ST_SQUARE);
	assign out_free = !res_valid_q || res_pop;

	rmsl_ram #(
		.WIDTH(MEAN_BITS),
		.DEPTH(MAX_ROWS)
	) u_means (
		.clk  (clk),
		.we   (ram_we),
		.waddr(job_q.row),
		.wdata(mean_q),
		.raddr(job.row),
		.rdata(mean_rd)
	);

	rmsl_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// operand preparation, sign-magnitude around the unsigned divider
	assign sum_abs    = job.sum[SUM_BITS-1] ? (~job.sum + SUM_BITS'(1)) : job.sum;
	assign wm         = job_q.weight * mean_rd;
	assign num        = {wm, 1'b0};
	assign num_abs    = num[NUM_BITS-1] ? (~num + NUM_BITS'(1)) : num;
	assign den_full   = job_q.len * job_q.rows;
	assign sq_full    = mean_q * mean_q;
	assign sqsum_next = square_sum_q + SQSUM_BITS'(sq_q);
	assign q          = div_rsp.quotient;

	always_comb begin
		div_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (!job_empty && (job.cmd == CMD_FORWARD)) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_BITS'(sum_abs);
					div_req.divisor  = DVS_BITS'(job.len);
				end
			end
			ST_READ: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_BITS'(num_abs);
				div_req.divisor  = den_full[DVS_BITS-1:0];
			end
			ST_ACCUM: begin
				if (job_q.last) begin
					div_req.start    = 1'b1;
					div_req.dividend = sqsum_next;
					div_req.divisor  = DVS_BITS'(job_q.rows);
				end
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	// round toward zero already holds; saturate and restore the sign
	always_comb begin
		if (sign_q) begin
			mean_sat = (q > MEAN_NEG_MAX) ? MEAN_BITS'(16'h8000)
				: MEAN_BITS'(~q[MEAN_BITS-1:0] + 1'b1);
			grad_sat = (q > GRAD_NEG_MAX) ? GRAD_BITS'(32'h8000_0000)
				: GRAD_BITS'(~q[GRAD_BITS-1:0] + 1'b1);
		end else begin
			mean_sat = (q > MEAN_POS_MAX) ? MEAN_BITS'(16'h7FFF) : q[MEAN_BITS-1:0];
			grad_sat = (q > GRAD_POS_MAX) ? GRAD_BITS'(32'h7FFF_FFFF) : q[GRAD_BITS-1:0];
		end
		loss_sat = (q > LOSS_MAX) ? '1 : q[LOSS_BITS-1:0];
	end

	always_comb begin
		res_next.kind       = (job_q.cmd == CMD_BACKWARD) ? KIND_BACKWARD : KIND_FORWARD;
		res_next.row        = job_q.row;
		res_next.mean       = mean_q;
		res_next.loss_valid = (job_q.cmd == CMD_FORWARD) && job_q.last;
		res_next.loss       = res_next.loss_valid ? loss_q : '0;
		res_next.gradient   = (job_q.cmd == CMD_BACKWARD) ? grad_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			res_valid_q  <= 1'b0;
			square_sum_q <= '0;
		end else begin
			if (res_pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						state_q <= (job.cmd == CMD_BACKWARD) ? ST_READ : ST_WAIT_MEAN;
					end
				end
				ST_READ: begin
					state_q <= ST_WAIT_GRAD;
				end
				ST_WAIT_GRAD: begin
					if (div_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_WAIT_MEAN: begin
					if (div_rsp.done) begin
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					state_q <= ST_ACCUM;
				end
				ST_ACCUM: begin
					square_sum_q <= job_q.last ? '0 : sqsum_next;
					state_q      <= job_q.last ? ST_WAIT_LOSS : ST_DONE;
				end
				ST_WAIT_LOSS: begin
					if (div_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q  <= job;
			sign_q <= job.sum[SUM_BITS-1];
		end
		if (state_q == ST_READ) begin
			mean_q <= mean_rd;
			sign_q <= num[NUM_BITS-1];
		end
		if ((state_q == ST_WAIT_MEAN) && div_rsp.done) begin
			mean_q <= mean_sat;
		end
		if (state_q == ST_SQUARE) begin
			sq_q <= sq_full[SQ_BITS-1:0];
		end
		if ((state_q == ST_WAIT_GRAD) && div_rsp.done) begin
			grad_q <= grad_sat;
		end
		if ((state_q == ST_WAIT_LOSS) && div_rsp.done) begin
			loss_q <= loss_sat;
		end
		if ((state_q == ST_DONE) && out_free) begin
			res_q <= res_next;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

>>> bench/tb.sv
module tb;
	import rmsl_pkg::*;

	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = 150;
	localparam int DRAIN_CYCLES  = 200;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          push = 1'b0;
	logic                          full;
	logic                          command = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic [ROW_BITS-1:0]           row_select = '0;
	logic signed [WEIGHT_BITS-1:0] loss_weight = '0;
	logic                          empty;
	logic                          pop = 1'b0;
	logic                          result_kind;
	logic [ROW_BITS-1:0]           row_number;
	logic signed [MEAN_BITS-1:0]   row_mean;
	logic                          loss_valid;
	logic [LOSS_BITS-1:0]          loss;
	logic signed [GRAD_BITS-1:0]   gradient;
	logic                          write_enable = 1'b0;
	logic [CFG_INDEX_BITS-1:0]     write_index = '0;
	logic [CFG_DATA_BITS-1:0]      write_data = '0;

	row_mean_square_loss u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.sample       (sample),
		.row_select   (row_select),
		.loss_weight  (loss_weight),
		.empty        (empty),
		.pop          (pop),
		.result_kind  (result_kind),
		.row_number   (row_number),
		.row_mean     (row_mean),
		.loss_valid   (loss_valid),
		.loss         (loss),
		.gradient     (gradient),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_data   (write_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow state of the loss block
	logic [LEN_BITS-1:0]         len_reg = 13'd1;
	logic [CNT_BITS-1:0]         cnt_reg = 11'd1;
	longint                      acc_sum = 0;
	int unsigned                 sample_pos = 0;
	logic [ROW_BITS-1:0]         row_ptr = '0;
	logic [SQSUM_BITS-1:0]       square_acc = '0;
	logic signed [MEAN_BITS-1:0] mean_store [MAX_ROWS];
	bit                          mean_known [MAX_ROWS];
	result_t                     mean_grad_queue [$];

	int          error_count = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          gradients_seen = 0;
	int          batches_closed = 0;
	int          reg_writes = 0;
	int          input_stalls = 0;
	int          burst_left = 1;
	int          hold_request = 0;
	int          hold_left = 0;
	int unsigned cycle_count = 0;
	int unsigned pattern_step = 0;
	logic [7:0]  pop_mask = 8'hFF;

	function automatic void loss_item_outcome(input cmd_t cmd, input logic signed [15:0] smp,
			input logic [ROW_BITS-1:0] sel, input logic signed [15:0] wgt);
		longint  len_eff;
		longint  cnt_eff;
		longint  mn;
		longint  grad;
		longint  loss_q;
		result_t out;
		len_eff = (len_reg == 0) ? 1 : ((len_reg > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : len_reg);
		cnt_eff = (cnt_reg == 0) ? 1 : ((cnt_reg > MAX_ROWS) ? MAX_ROWS : cnt_reg);
		out = '0;
		if (cmd == CMD_BACKWARD) begin
			mn = mean_store[sel];
			grad = (2 * longint'(wgt) * mn) / (cnt_eff * len_eff);
			if (grad > 64'sd2147483647)
				grad = 64'sd2147483647;
			else if (grad < -64'sd2147483648)
				grad = -64'sd2147483648;
			out.kind     = KIND_BACKWARD;
			out.row      = sel;
			out.mean     = mn[15:0];
			out.gradient = grad[31:0];
			mean_grad_queue.push_back(out);
			return;
		end
		acc_sum += longint'(smp);
		if (longint'(sample_pos) + 1 < len_eff) begin
			sample_pos++;
			return;
		end
		mn = acc_sum / len_eff;
		if (mn > 32767)
			mn = 32767;
		else if (mn < -32768)
			mn = -32768;
		mean_store[row_ptr] = mn[15:0];
		mean_known[row_ptr] = 1'b1;
		square_acc = square_acc + SQSUM_BITS'(mn * mn);
		out.kind = KIND_FORWARD;
		out.row  = row_ptr;
		out.mean = mn[15:0];
		if (longint'(row_ptr) + 1 >= cnt_eff) begin
			loss_q = longint'(square_acc) / cnt_eff;
			if (loss_q > longint'(32'hFFFF_FFFF))
				loss_q = longint'(32'hFFFF_FFFF);
			out.loss_valid = 1'b1;
			out.loss       = loss_q[31:0];
			square_acc     = '0;
			row_ptr        = '0;
		end else begin
			row_ptr = row_ptr + 1'b1;
		end
		acc_sum = 0;
		sample_pos = 0;
		mean_grad_queue.push_back(out);
	endfunction

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t mismatch on %s: expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	// result side: check, then pick the next pop
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (mean_grad_queue.size() == 0) begin
					error_count++;
					$display("%0t unexpected result: row %0d kind %0b", $time, row_number,
						result_kind);
				end else begin
					results_seen++;
					if (mean_grad_queue[0].kind == KIND_BACKWARD)
						gradients_seen++;
					if (mean_grad_queue[0].loss_valid)
						batches_closed++;
					check_field("result_kind", mean_grad_queue[0].kind, result_kind);
					check_field("row_number", mean_grad_queue[0].row, row_number);
					check_field("row_mean", mean_grad_queue[0].mean, row_mean);
					check_field("loss_valid", mean_grad_queue[0].loss_valid, loss_valid);
					check_field("loss", mean_grad_queue[0].loss, loss);
					check_field("gradient", mean_grad_queue[0].gradient, gradient);
					void'(mean_grad_queue.pop_front());
				end
			end
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pattern_step++;
				if (pattern_step[5:0] == 6'd0) begin
					pop_mask = $urandom;
					if ($urandom_range(0, 3) == 0)
						pop_mask = 8'hFF;
					if (pop_mask == 8'h00)
						pop_mask = 8'h5A;
				end
				pop <= pop_mask[pattern_step[2:0]];
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still awaited", cycle_count,
				mean_grad_queue.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_item(input cmd_t cmd, input logic signed [15:0] smp,
			input logic [ROW_BITS-1:0] sel, input logic signed [15:0] wgt);
		int gap;
		push        <= 1'b1;
		command     <= cmd;
		sample      <= smp;
		row_select  <= sel;
		loss_weight <= wgt;
		do begin
			@(posedge clk);
			if (full)
				input_stalls++;
		end while (full);
		items_sent++;
		loss_item_outcome(cmd, smp, sel, wgt);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 5);
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_sample(input logic signed [15:0] smp);
		send_item(CMD_FORWARD, smp, ROW_BITS'($urandom), WEIGHT_BITS'($urandom));
	endtask

	task automatic send_gradient(input logic [ROW_BITS-1:0] sel, input logic signed [15:0] wgt);
		send_item(CMD_BACKWARD, SAMPLE_BITS'($urandom), sel, wgt);
	endtask

	// block idle: no result owed and the divider has had time to finish
	task automatic wait_idle();
		push <= 1'b0;
		while (mean_grad_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		wait_idle();
		write_enable <= 1'b1;
		write_index  <= idx;
		write_data   <= value;
		@(posedge clk);
		write_enable <= 1'b0;
		reg_writes++;
		if (idx == REG_ROW_LENGTH)
			len_reg = value;
		else
			cnt_reg = value[CNT_BITS-1:0];
	endtask

	task automatic test_reset_values();
		send_sample(16'sh7FFF);
		send_sample(-16'sd32768);
		send_gradient(10'd0, -16'sd32768);
		send_gradient(10'd0, 16'sd32767);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sd0);
		send_gradient(10'd0, 16'sd0);
	endtask

	task automatic test_row_rounding();
		write_register(REG_ROW_LENGTH, 13'd4);
		write_register(REG_ROW_COUNT, 13'd3);
		send_sample(16'sd1);
		send_sample(16'sd1);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(-16'sd1);
		send_sample(-16'sd1);
		send_sample(-16'sd1);
		send_sample(-16'sd2);
		repeat (4) send_sample(16'sh7FFF);
		send_gradient(10'd0, 16'sd32767);
		send_gradient(10'd1, -16'sd32768);
		send_gradient(10'd2, -16'sd32768);
	endtask

	task automatic test_register_edges();
		// zero registers act as one
		write_register(REG_ROW_LENGTH, 13'd0);
		write_register(REG_ROW_COUNT, 13'd0);
		send_sample(16'sd12345);
		send_gradient(10'd0, -16'sd32768);
		// oversized registers clamp, count keeps its low bits only
		write_register(REG_ROW_LENGTH, 13'h1FFF);
		write_register(REG_ROW_COUNT, 13'h1FFF);
		send_gradient(10'd0, 16'sd32767);
		// shrinking the row mid-way saturates the mean
		write_register(REG_ROW_LENGTH, 13'd8);
		write_register(REG_ROW_COUNT, 13'd16);
		repeat (4) send_sample(16'sh7FFF);
		write_register(REG_ROW_LENGTH, 13'd1);
		send_sample(16'sh7FFF);
		write_register(REG_ROW_LENGTH, 13'd8);
		repeat (4) send_sample(-16'sd32768);
		write_register(REG_ROW_LENGTH, 13'd2);
		send_sample(-16'sd32768);
		// shrinking the batch mid-way saturates the loss
		write_register(REG_ROW_LENGTH, 13'd1);
		repeat (6) send_sample(-16'sd32768);
		write_register(REG_ROW_COUNT, 13'd2);
		send_sample(-16'sd32768);
	endtask

	task automatic test_longest_row();
		write_register(REG_ROW_LENGTH, 13'd4096);
		write_register(REG_ROW_COUNT, 13'd1);
		repeat (MAX_ROW_LENGTH) send_sample(-16'sd32768);
		send_gradient(10'd0, -16'sd32768);
		send_gradient(10'd0, 16'sd1);
	endtask

	task automatic test_full_batch();
		write_register(REG_ROW_LENGTH, 13'd1);
		write_register(REG_ROW_COUNT, 13'd1024);
		repeat (MAX_ROWS) send_sample(SAMPLE_BITS'($urandom));
		send_gradient(10'd1023, -16'sd32768);
		send_gradient(10'd511, 16'sd32767);
	endtask

	task automatic test_input_stall();
		write_register(REG_ROW_COUNT, 13'd5);
		hold_request = 600;
		repeat (40) send_sample(SAMPLE_BITS'($urandom));
	endtask

	task automatic test_random_batches();
		int                   start;
		int                   n;
		logic [ROW_BITS-1:0]  sel;
		logic signed [15:0]   smp;
		logic [CFG_DATA_BITS-1:0] value;
		start = items_sent;
		while (items_sent - start < 1000) begin
			case ($urandom_range(0, 19))
				0:       value = 13'd0;
				1:       value = $urandom_range(65, 200);
				2, 3, 4: value = $urandom_range(9, 64);
				default: value = $urandom_range(1, 8);
			endcase
			write_register(REG_ROW_LENGTH, value);
			case ($urandom_range(0, 19))
				0:          value = 13'd0;
				1:          value = $urandom_range(1025, 2047);
				2:          value = CFG_DATA_BITS'($urandom);
				3, 4, 5, 6: value = $urandom_range(7, 40);
				default:    value = $urandom_range(1, 6);
			endcase
			write_register(REG_ROW_COUNT, value);
			n = $urandom_range(40, 120);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0) begin
					do sel = ROW_BITS'($urandom); while (!mean_known[sel]);
					send_gradient(sel, WEIGHT_BITS'($urandom));
				end else begin
					case ($urandom_range(0, 9))
						0:       smp = 16'sh7FFF;
						1:       smp = -16'sd32768;
						2:       smp = 16'(int'($urandom_range(0, 2)) - 1);
						3, 4:    smp = 16'(int'($urandom_range(0, 128)) - 64);
						default: smp = SAMPLE_BITS'($urandom);
					endcase
					send_sample(smp);
				end
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_row_rounding();
		test_register_edges();
		test_longest_row();
		test_full_batch();
		test_input_stall();
		test_random_batches();
		wait_idle();
		repeat (DRAIN_CYCLES - SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d requests, checked %0d results: %0d gradients, %0d closed batches",
			items_sent, results_seen, gradients_seen, batches_closed);
		$display("%0d register writes incl. clamped values, %0d cycles with the input held off",
			reg_writes, input_stalls);
		if (error_count == 0 && mean_grad_queue.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results never arrived", error_count,
				mean_grad_queue.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/rmsl_pkg.sv
hw/rtl/rmsl_ram.sv
hw/rtl/rmsl_queue.sv
hw/rtl/rmsl_div.sv
hw/rtl/rmsl_front.sv
hw/rtl/rmsl_back.sv
hw/rtl/row_mean_square_loss.sv
bench/tb.sv
